// ----- hw/rtl/rat_pkg.sv -----
`default_nettype none
package rat_pkg;

	localparam int ENTRIES    = 16;
	localparam int COORD_BITS = 16;
	localparam int CNT_W      = $clog2(ENTRIES + 1);

	typedef logic [COORD_BITS-1:0] coord_t;
	typedef logic [CNT_W-1:0]      count_t;
	typedef logic [2:0]            opcode_t;
	typedef logic [1:0]            status_t;

	// command opcodes
	localparam opcode_t OP_ALLOC   = 3'd0;
	localparam opcode_t OP_RELEASE = 3'd1;
	localparam opcode_t OP_CHECK   = 3'd2;
	localparam opcode_t OP_LIST    = 3'd3;
	localparam opcode_t OP_MERGED  = 3'd4;

	// result status codes
	localparam status_t STAT_OK      = 2'd0;
	localparam status_t STAT_INVALID = 2'd1;
	localparam status_t STAT_FULL    = 2'd2;
	localparam status_t STAT_EMPTY   = 2'd3;

	// cell actions broadcast along the chain
	typedef logic [1:0] act_t;
	localparam act_t ACT_HOLD   = 2'd0;
	localparam act_t ACT_REMOVE = 2'd1;
	localparam act_t ACT_INSERT = 2'd2;
	localparam act_t ACT_ROTATE = 2'd3;

	// one table slot
	typedef struct packed {
		logic   valid;
		coord_t lo;
		coord_t hi;
	} cell_t;

	// command broadcast to every cell
	typedef struct packed {
		act_t   act;
		coord_t lo;
		coord_t hi;
		cell_t  head;
	} cell_cmd_t;

endpackage
`default_nettype wire

// ----- hw/rtl/rat_cell.sv -----
`default_nettype none
module rat_cell (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire rat_pkg::cell_cmd_t cmd,
	input  wire rat_pkg::cell_t    left,
	input  wire logic              left_precedes,
	input  wire rat_pkg::cell_t    right,
	input  wire logic              kill_in,
	output rat_pkg::cell_t         slot,
	output logic                   precedes,
	output logic                   kill_out
);
	import rat_pkg::*;

	cell_t slot_q;
	cell_t slot_d;
	logic  ovl;

	assign slot = slot_q;

	// compare the command span against this slot
	assign ovl      = slot_q.valid && (cmd.lo < slot_q.hi) && (cmd.hi > slot_q.lo);
	assign kill_out = kill_in | ovl;
	assign precedes = slot_q.valid && ((slot_q.lo < cmd.lo) ||
		((slot_q.lo == cmd.lo) && (slot_q.hi <= cmd.hi)));

	// pick the next slot contents
	always_comb begin
		slot_d = slot_q;
		case (cmd.act)
			ACT_REMOVE: begin
				if (kill_out) slot_d = right;
			end
			ACT_INSERT: begin
				if (!precedes) begin
					if (left_precedes) slot_d = '{valid: 1'b1, lo: cmd.lo, hi: cmd.hi};
					else               slot_d = left;
				end
			end
			ACT_ROTATE: begin
				if (right.valid)       slot_d = right;
				else if (slot_q.valid) slot_d = cmd.head;
			end
			default: begin
				slot_d = slot_q;
			end
		endcase
	end

	// advance the slot; reset empties it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) slot_q <= '0;
		else         slot_q <= slot_d;
	end

endmodule
`default_nettype wire

// ----- hw/rtl/range_allocation_table_core.sv -----
// Range allocation table: a sorted table of disjoint half-open ranges.
// Input channel (in_valid/in_ready) carries opcode, range_start, range_end.
// Output channel (out_valid/out_ready) carries status, is_free, out_start,
// out_end and last; every command ends with one result that has last set.
// The table is a chain of ENTRIES cells; a command is broadcast to all cells
// and each cell shifts toward or from its neighbor in the same cycle.
// One command is worked at a time; in_ready is high only while idle.
// Check and invalid commands give their result from the execute state;
// allocate and release first remove every overlapping range (the chain
// drops one overlapping range per cycle). Lists rotate the chain once per
// stored range: a stored list gives one result per cycle while out_ready
// holds, a merged list one per run of touching ranges. A new item is taken
// the cycle after the last result is produced; none is taken before.
// The output register holds a result while out_ready is low; the chain
// then stops before its next result until the held result is taken.
// Reset empties the table (all cells invalid, count zero) and clears out_valid.
`default_nettype none
module range_allocation_table_core (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire rat_pkg::opcode_t  opcode,
	input  wire rat_pkg::coord_t   range_start,
	input  wire rat_pkg::coord_t   range_end,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output rat_pkg::status_t       status,
	output logic                   is_free,
	output rat_pkg::coord_t        out_start,
	output rat_pkg::coord_t        out_end,
	output logic                   last
);
	import rat_pkg::*;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_EXEC = 2'd1;
	localparam logic [1:0] S_LIST = 2'd2;

	logic [1:0] state_q, state_d;
	opcode_t    op_q;
	coord_t     lo_q, hi_q;
	count_t     count_q, count_d;
	count_t     idx_q, idx_d;
	coord_t     mlo_q, mlo_d, mhi_q, mhi_d;

	cell_cmd_t  cmd;
	act_t       act;
	cell_t      cells    [ENTRIES];
	logic       precedes [ENTRIES];
	logic       kill     [ENTRIES];
	logic       any_ovl;

	logic       can_emit, emit;
	status_t    e_status;
	logic       e_free, e_last;
	coord_t     e_lo, e_hi;

	assign in_ready = (state_q == S_IDLE);
	assign can_emit = !out_valid || out_ready;
	assign any_ovl  = kill[ENTRIES-1];

	assign cmd = '{act: act, lo: lo_q, hi: hi_q, head: cells[0]};

	// build the chain of cells
	for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
		cell_t lft, rgt;
		logic  lft_precedes, kin;
		if (i == 0) begin : g_first
			assign lft          = '0;
			assign lft_precedes = 1'b1;
			assign kin          = 1'b0;
		end else begin : g_mid
			assign lft          = cells[i-1];
			assign lft_precedes = precedes[i-1];
			assign kin          = kill[i-1];
		end
		if (i == ENTRIES - 1) begin : g_last
			assign rgt = '0;
		end else begin : g_inner
			assign rgt = cells[i+1];
		end
		rat_cell u_cell (
			.clk           (clk),
			.arst_n        (arst_n),
			.cmd           (cmd),
			.left          (lft),
			.left_precedes (lft_precedes),
			.right         (rgt),
			.kill_in       (kin),
			.slot          (cells[i]),
			.precedes      (precedes[i]),
			.kill_out      (kill[i])
		);
	end

	// sequence the command
	always_comb begin
		state_d  = state_q;
		count_d  = count_q;
		idx_d    = idx_q;
		mlo_d    = mlo_q;
		mhi_d    = mhi_q;
		act      = ACT_HOLD;
		emit     = 1'b0;
		e_status = STAT_OK;
		e_free   = 1'b0;
		e_last   = 1'b1;
		e_lo     = '0;
		e_hi     = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) state_d = S_EXEC;
			end
			S_EXEC: begin
				case (op_q)
					OP_ALLOC, OP_RELEASE, OP_CHECK: begin
						if (!(lo_q < hi_q)) begin
							e_status = STAT_INVALID;
							emit     = can_emit;
						end else if (op_q == OP_CHECK) begin
							e_free = !any_ovl;
							emit   = can_emit;
						end else if (any_ovl) begin
							act     = ACT_REMOVE;
							count_d = count_q - count_t'(1);
						end else if (op_q == OP_RELEASE) begin
							emit = can_emit;
						end else if (count_q == count_t'(ENTRIES)) begin
							e_status = STAT_FULL;
							emit     = can_emit;
						end else if (can_emit) begin
							act     = ACT_INSERT;
							count_d = count_q + count_t'(1);
							emit    = 1'b1;
						end
						if (emit) state_d = S_IDLE;
					end
					OP_LIST, OP_MERGED: begin
						if (count_q == '0) begin
							e_status = STAT_EMPTY;
							emit     = can_emit;
							if (emit) state_d = S_IDLE;
						end else begin
							idx_d   = '0;
							state_d = S_LIST;
						end
					end
					default: begin
						e_status = STAT_INVALID;
						emit     = can_emit;
						if (emit) state_d = S_IDLE;
					end
				endcase
			end
			S_LIST: begin
				if (op_q == OP_LIST) begin
					e_lo   = cells[0].lo;
					e_hi   = cells[0].hi;
					e_last = (idx_q == count_q - count_t'(1));
					if (can_emit) begin
						emit  = 1'b1;
						act   = ACT_ROTATE;
						idx_d = idx_q + count_t'(1);
						if (e_last) state_d = S_IDLE;
					end
				end else if (idx_q == '0) begin
					mlo_d = cells[0].lo;
					mhi_d = cells[0].hi;
					act   = ACT_ROTATE;
					idx_d = count_t'(1);
				end else if (idx_q == count_q) begin
					e_lo = mlo_q;
					e_hi = mhi_q;
					emit = can_emit;
					if (emit) state_d = S_IDLE;
				end else if (cells[0].lo <= mhi_q) begin
					if (cells[0].hi > mhi_q) mhi_d = cells[0].hi;
					act   = ACT_ROTATE;
					idx_d = idx_q + count_t'(1);
				end else begin
					e_lo   = mlo_q;
					e_hi   = mhi_q;
					e_last = 1'b0;
					if (can_emit) begin
						emit  = 1'b1;
						mlo_d = cells[0].lo;
						mhi_d = cells[0].hi;
						act   = ACT_ROTATE;
						idx_d = idx_q + count_t'(1);
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// hold control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			count_q   <= '0;
			out_valid <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			if (emit)           out_valid <= 1'b1;
			else if (out_ready) out_valid <= 1'b0;
		end
	end

	// capture the command and the working registers
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			op_q <= opcode;
			lo_q <= range_start;
			hi_q <= range_end;
		end
		idx_q <= idx_d;
		mlo_q <= mlo_d;
		mhi_q <= mhi_d;
		if (emit) begin
			status    <= e_status;
			is_free   <= e_free;
			out_start <= e_lo;
			out_end   <= e_hi;
			last      <= e_last;
		end
	end

endmodule
`default_nettype wire

// ----- hw/rtl/rat_checker.sv -----
`default_nettype none
module rat_checker (
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             in_valid,
	input wire logic             in_ready,
	input wire logic             out_valid,
	input wire logic             out_ready,
	input wire rat_pkg::status_t status,
	input wire logic             is_free,
	input wire rat_pkg::coord_t  out_start,
	input wire rat_pkg::coord_t  out_end,
	input wire logic             last
);
	import rat_pkg::*;

	// one command at a time: ready drops after an accept
	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("input accepted while a command was in flight");

	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(status) && $stable(last)
			&& $stable(out_start) && $stable(out_end)))
		else $error("stalled result changed");

	// empty list result is a bare final item
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == STAT_EMPTY) |-> (last && out_start == '0 && out_end == '0))
		else $error("empty status with coordinates or without last");

	// free flag only on a single ok check result
	a_free: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && is_free) |-> (status == STAT_OK && last && out_start == '0))
		else $error("is_free on a non-check result");

	// a result that is not last is a listed, well-formed range
	a_mid: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !last) |-> (status == STAT_OK && out_start < out_end))
		else $error("bad intermediate list result");

endmodule

bind range_allocation_table_core rat_checker u_rat_checker (.*);
`default_nettype wire

// ----- tb/testbench.sv -----
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import rat_pkg::*;

	// opcodes the block does not define; they must answer with an invalid status
	localparam opcode_t OP_SPARE_LO = 3'd5;
	localparam opcode_t OP_SPARE_HI = 3'd7;

	localparam coord_t COORD_TOP = {COORD_BITS{1'b1}};

	typedef struct packed {
		status_t st;
		logic    free;
		coord_t  lo;
		coord_t  hi;
		logic    fin;
	} reply_t;

	logic    clk = 1'b0;
	logic    arst_n = 1'b0;
	logic    in_valid = 1'b0;
	logic    in_ready;
	opcode_t opcode = OP_ALLOC;
	coord_t  range_start = '0;
	coord_t  range_end = '0;
	logic    out_valid;
	logic    out_ready = 1'b0;
	status_t status;
	logic    is_free;
	coord_t  out_start;
	coord_t  out_end;
	logic    last;

	// shadow copy of the range table
	coord_t held_lo [ENTRIES];
	coord_t held_hi [ENTRIES];
	int     held_count = 0;

	reply_t pending_replies[$];
	int     fail_count = 0;
	bit     idle_on = 1'b1;
	int     stall_left = 0;

	range_allocation_table_core DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.opcode     (opcode),
		.range_start(range_start),
		.range_end  (range_end),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.status     (status),
		.is_free    (is_free),
		.out_start  (out_start),
		.out_end    (out_end),
		.last       (last)
	);

	always #5ns clk = ~clk;

	// drop every held range that overlaps [s,e), keeping order
	function automatic void cut_overlaps(coord_t s, coord_t e);
		int kept;
		kept = 0;
		for (int i = 0; i < held_count; i++) begin
			if (!(s < held_hi[i] && e > held_lo[i])) begin
				held_lo[kept] = held_lo[i];
				held_hi[kept] = held_hi[i];
				kept++;
			end
		end
		held_count = kept;
	endfunction

	// place [s,e) in start order; refuse when the table is full
	function automatic bit insert_range(coord_t s, coord_t e);
		int pos;
		pos = 0;
		if (held_count >= ENTRIES)
			return 1'b0;
		while (pos < held_count &&
		       (held_lo[pos] < s || (held_lo[pos] == s && held_hi[pos] <= e)))
			pos++;
		for (int i = held_count; i > pos; i--) begin
			held_lo[i] = held_lo[i-1];
			held_hi[i] = held_hi[i-1];
		end
		held_lo[pos] = s;
		held_hi[pos] = e;
		held_count++;
		return 1'b1;
	endfunction

	function automatic reply_t make_reply(status_t st, logic free, coord_t lo, coord_t hi,
	                                     logic fin);
		reply_t r;
		r.st   = st;
		r.free = free;
		r.lo   = lo;
		r.hi   = hi;
		r.fin  = fin;
		return r;
	endfunction

	// append one forecast result at the tail of the queue
	function automatic void queue_reply(reply_t r);
		pending_replies.insert(pending_replies.size(), r);
	endfunction

	// update the shadow table and queue the results one command causes
	function automatic void forecast_results(opcode_t op, coord_t s, coord_t e);
		bit     free;
		coord_t run_lo;
		coord_t run_hi;
		case (op)
			OP_ALLOC, OP_RELEASE, OP_CHECK: begin
				if (s >= e) begin
					queue_reply(make_reply(STAT_INVALID, 1'b0, '0, '0, 1'b1));
				end else if (op == OP_ALLOC) begin
					cut_overlaps(s, e);
					queue_reply(make_reply(insert_range(s, e) ? STAT_OK : STAT_FULL,
					                       1'b0, '0, '0, 1'b1));
				end else if (op == OP_RELEASE) begin
					cut_overlaps(s, e);
					queue_reply(make_reply(STAT_OK, 1'b0, '0, '0, 1'b1));
				end else begin
					free = 1'b1;
					for (int i = 0; i < held_count; i++)
						if (s < held_hi[i] && e > held_lo[i])
							free = 1'b0;
					queue_reply(make_reply(STAT_OK, free, '0, '0, 1'b1));
				end
			end
			OP_LIST, OP_MERGED: begin
				if (held_count == 0) begin
					queue_reply(make_reply(STAT_EMPTY, 1'b0, '0, '0, 1'b1));
				end else if (op == OP_LIST) begin
					for (int i = 0; i < held_count; i++)
						queue_reply(make_reply(STAT_OK, 1'b0, held_lo[i], held_hi[i],
						                       i + 1 == held_count));
				end else begin
					run_lo = held_lo[0];
					run_hi = held_hi[0];
					for (int i = 1; i < held_count; i++) begin
						if (held_lo[i] <= run_hi) begin
							if (held_hi[i] > run_hi)
								run_hi = held_hi[i];
						end else begin
							queue_reply(make_reply(STAT_OK, 1'b0, run_lo, run_hi, 1'b0));
							run_lo = held_lo[i];
							run_hi = held_hi[i];
						end
					end
					queue_reply(make_reply(STAT_OK, 1'b0, run_lo, run_hi, 1'b1));
				end
			end
			default: begin
				queue_reply(make_reply(STAT_INVALID, 1'b0, '0, '0, 1'b1));
			end
		endcase
	endfunction

	// present one item, hold it until accepted, then forecast its results
	task automatic send_item(opcode_t op, coord_t s, coord_t e);
		if (idle_on && $urandom_range(0, 2) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
		in_valid    <= 1'b1;
		opcode      <= op;
		range_start <= s;
		range_end   <= e;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		forecast_results(op, s, e);
	endtask

	// stall the result side in random bursts
	always @(posedge clk) begin
		if (stall_left > 0) begin
			out_ready  <= 1'b0;
			stall_left <= stall_left - 1;
		end else if (idle_on && $urandom_range(0, 5) == 0) begin
			out_ready  <= 1'b0;
			stall_left <= $urandom_range(0, 12);
		end else begin
			out_ready <= 1'b1;
		end
	end

	// compare each accepted result with the oldest forecast
	always @(posedge clk) begin : check_results
		reply_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_replies.size() == 0) begin
				fail_count++;
				if (fail_count <= 10)
					$display("unexpected result: status %0d free %0b start %0h end %0h last %0b",
					         status, is_free, out_start, out_end, last);
			end else begin
				want = pending_replies.pop_front();
				if (status !== want.st || is_free !== want.free || out_start !== want.lo ||
				    out_end !== want.hi || last !== want.fin) begin
					fail_count++;
					if (fail_count <= 10) begin
						$display("result mismatch: expected status %0d free %0b start %0h end %0h last %0b",
						         want.st, want.free, want.lo, want.hi, want.fin);
						$display("                 got status %0d free %0b start %0h end %0h last %0b",
						         status, is_free, out_start, out_end, last);
					end
				end
			end
		end
	end

	// pick a span: mostly small spans on a coarse grid so ranges touch and overlap
	task automatic pick_span(output coord_t s, output coord_t e);
		int mode;
		int a;
		int b;
		mode = $urandom_range(0, 19);
		if (mode == 0) begin
			s = coord_t'($urandom);
			e = coord_t'($urandom);
		end else if (mode == 1) begin
			s = coord_t'($urandom);
			e = s;
		end else if (mode == 2) begin
			a = int'(COORD_TOP) - $urandom_range(1, 300);
			b = a + $urandom_range(1, int'(COORD_TOP) - a);
			s = coord_t'(a);
			e = coord_t'(b);
		end else begin
			a = 8 * $urandom_range(0, 100);
			b = a + 8 * $urandom_range(1, 4);
			if ($urandom_range(0, 3) == 0)
				b = b - $urandom_range(0, 7);
			s = coord_t'(a);
			e = coord_t'(b);
		end
	endtask

	function automatic opcode_t pick_opcode();
		int r;
		r = $urandom_range(0, 99);
		if (r < 36)
			return OP_ALLOC;
		else if (r < 52)
			return OP_RELEASE;
		else if (r < 72)
			return OP_CHECK;
		else if (r < 82)
			return OP_LIST;
		else if (r < 92)
			return OP_MERGED;
		return opcode_t'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
	endfunction

	// lists, check and release on an empty table
	task automatic test_empty_table();
		send_item(OP_LIST, '0, '0);
		send_item(OP_MERGED, COORD_TOP, COORD_TOP);
		send_item(OP_CHECK, '0, COORD_TOP);
		send_item(OP_RELEASE, 16'd5, 16'd10);
	endtask

	// reversed or empty spans and undefined opcodes
	task automatic test_bad_items();
		send_item(OP_ALLOC, 16'd100, 16'd100);
		send_item(OP_RELEASE, 16'd200, 16'd100);
		send_item(OP_CHECK, COORD_TOP, '0);
		for (int op = OP_SPARE_LO; op <= OP_SPARE_HI; op++)
			send_item(opcode_t'(op), 16'h1234, 16'hABCD);
	endtask

	// edge coordinates, replacement of overlapped ranges, merging of touching ones
	task automatic test_boundary_ranges();
		send_item(OP_ALLOC, '0, 16'd1);
		send_item(OP_ALLOC, COORD_TOP - 16'd1, COORD_TOP);
		send_item(OP_ALLOC, 16'd1, 16'd10);
		send_item(OP_ALLOC, 16'd5, 16'd20);
		send_item(OP_ALLOC, 16'd20, 16'd30);
		send_item(OP_CHECK, 16'd9, 16'd10);
		send_item(OP_CHECK, 16'd30, COORD_TOP - 16'd1);
		send_item(OP_LIST, '0, '0);
		send_item(OP_MERGED, '0, '0);
		send_item(OP_RELEASE, 16'd15, 16'd16);
		send_item(OP_LIST, '0, '0);
		send_item(OP_ALLOC, '0, COORD_TOP);
		send_item(OP_MERGED, '0, '0);
		send_item(OP_RELEASE, '0, COORD_TOP);
	endtask

	// fill the table out of order, then overflow it and free room by overlap
	task automatic test_full_table();
		int k;
		for (int i = 0; i < ENTRIES; i++) begin
			k = (i * 7) % ENTRIES;
			send_item(OP_ALLOC, coord_t'(k * 100 + 10), coord_t'(k * 100 + 60));
		end
		send_item(OP_ALLOC, 16'd5000, 16'd5010);
		send_item(OP_CHECK, 16'd5000, 16'd5010);
		send_item(OP_LIST, '0, '0);
		send_item(OP_MERGED, '0, '0);
		send_item(OP_ALLOC, '0, 16'd250);
		send_item(OP_LIST, '0, '0);
		send_item(OP_RELEASE, '0, COORD_TOP);
	endtask

	// random command mix with an occasional wipe of the whole table
	task automatic test_random_traffic(int count);
		opcode_t op;
		coord_t  s;
		coord_t  e;
		for (int n = 0; n < count; n++) begin
			if ($urandom_range(0, 79) == 0) begin
				send_item(OP_RELEASE, '0, COORD_TOP);
			end else begin
				op = pick_opcode();
				pick_span(s, e);
				send_item(op, s, e);
			end
		end
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_table();
		test_bad_items();
		test_boundary_ranges();
		test_full_table();
		test_random_traffic(200);
		idle_on = 1'b0;
		test_random_traffic(70);
		in_valid <= 1'b0;
		while (pending_replies.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		if (fail_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	// end a hung run
	initial begin
		#5ms;
		$display("tb: failure");
		$finish;
	end

endmodule
